@@ src/tkrit_pkg.sv @@
// Package for the ranked insert table: sizes, entry and command types,
// controller states and the ordering function.
// No dependencies; used by every module of the block.
package tkrit_pkg;

    localparam int DEPTH   = 16;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int SCORE_W = 32;
    localparam int STEPS_W = 24;
    localparam int STAMP_W = 32;
    localparam int IDX_W   = 4;
    localparam int RANK_W  = 5;
    localparam int ENTRY_W = SCORE_W + STEPS_W + STAMP_W;

    localparam int IN_FIELDS_W  = ENTRY_W + IDX_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * RANK_W + ENTRY_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    // The score sits in the low bits, so the layout matches the beat packing.
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [STEPS_W-1:0] steps;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PLACE,
        ST_DROP,
        ST_READ,
        ST_RDOUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic scan;
        logic pos_load;
        logic shift;
        logic place;
        logic read;
        logic load_drop;
        logic load_rd;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic drop;
        logic no_move;
        logic shift_done;
    } t_dp_sts;

    // True when a new entry must stand ahead of the stored one.
    function automatic logic goes_before(input logic [SCORE_W-1:0] score,
                                         input logic [STEPS_W-1:0] steps,
                                         input t_entry stored);
        logic res;
        if (score != stored.score) begin
            res = (score > stored.score);
        end else begin
            res = (steps < stored.steps);
        end
        return res;
    endfunction

endpackage

@@ src/tkrit_datapath.sv @@
// Datapath of the ranked insert table: entry memory, scan and shift pointers,
// fill count and the result register. Depends on tkrit_pkg.
module tkrit_datapath import tkrit_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser
);

    t_entry          r_mem [DEPTH];
    t_entry          r_rd_data;
    t_entry          r_new;
    logic [IDX_W-1:0] r_idx;
    logic [CW-1:0]   r_fill;
    logic [CW-1:0]   r_ptr;
    logic            r_cmp_vld;
    logic [CW-1:0]   r_pos;
    logic            r_mv_vld;
    logic [CW-1:0]   r_mv_dst;

    logic [RANK_W-1:0] r_out_rank;
    logic [RANK_W-1:0] r_out_fill;
    logic              r_out_evld;
    t_entry            r_out_entry;

    logic          w_hit;
    logic [CW-1:0] w_pos;
    logic [CW-1:0] w_top;
    logic [CW-1:0] w_src;
    logic [CW-1:0] w_fill_inc;
    logic [AW-1:0] w_rd_addr;
    logic          w_rd_en;
    logic          w_idx_used;

    // The entry read last cycle belongs to position r_ptr - 1.
    assign w_hit      = r_cmp_vld && goes_before(r_new.score, r_new.steps, r_rd_data);
    assign w_pos      = w_hit ? (r_ptr - CW'(1)) : r_fill;
    assign w_top      = (r_fill == CW'(DEPTH)) ? CW'(DEPTH - 1) : r_fill;
    assign w_src      = r_ptr - CW'(1);
    assign w_fill_inc = (r_fill == CW'(DEPTH)) ? r_fill : (r_fill + CW'(1));
    assign w_idx_used = (int'(r_idx) < int'(r_fill));

    assign o_sts.scan_done  = w_hit || (r_ptr == r_fill);
    assign o_sts.drop       = (w_pos == CW'(DEPTH));
    assign o_sts.no_move    = (w_top == w_pos);
    assign o_sts.shift_done = r_mv_vld && (r_mv_dst == (r_pos + CW'(1)));

    always_comb begin
        w_rd_en = i_cmd.scan || i_cmd.shift || i_cmd.read;
        if (i_cmd.shift) begin
            w_rd_addr = w_src[AW-1:0];
        end else if (i_cmd.read) begin
            w_rd_addr = AW'(r_idx);
        end else begin
            w_rd_addr = r_ptr[AW-1:0];
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift && r_mv_vld) begin
            r_mem[r_mv_dst[AW-1:0]] <= r_rd_data;
        end else if (i_cmd.place) begin
            r_mem[r_pos[AW-1:0]] <= r_new;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
            r_mv_vld  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_ptr     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.pos_load) begin
                r_ptr    <= w_top;
                r_mv_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                if (r_ptr < r_fill) begin
                    r_ptr <= r_ptr + CW'(1);
                end
                r_cmp_vld <= (r_ptr < r_fill);
            end else if (i_cmd.shift) begin
                if (r_ptr > r_pos) begin
                    r_ptr    <= w_src;
                    r_mv_vld <= 1'b1;
                end else begin
                    r_mv_vld <= 1'b0;
                end
            end
            if (i_cmd.place) begin
                r_fill <= w_fill_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_new <= i_s_tdata[ENTRY_W-1:0];
            r_idx <= i_s_tdata[ENTRY_W +: IDX_W];
        end
        if (i_cmd.pos_load) begin
            r_pos <= w_pos;
        end
        if (i_cmd.shift) begin
            r_mv_dst <= r_ptr;
        end
        if (i_cmd.place) begin
            r_out_rank  <= RANK_W'(r_pos + CW'(1));
            r_out_fill  <= RANK_W'(w_fill_inc);
            r_out_evld  <= 1'b0;
            r_out_entry <= '0;
        end else if (i_cmd.load_drop) begin
            r_out_rank  <= '0;
            r_out_fill  <= RANK_W'(r_fill);
            r_out_evld  <= 1'b0;
            r_out_entry <= '0;
        end else if (i_cmd.load_rd) begin
            r_out_rank  <= '0;
            r_out_fill  <= RANK_W'(r_fill);
            r_out_evld  <= w_idx_used;
            r_out_entry <= w_idx_used ? r_rd_data : '0;
        end
    end

    assign o_m_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, r_out_entry, r_out_fill,
                        r_out_rank};
    assign o_m_tuser = r_out_evld;

endmodule

@@ src/tkrit_ctrl.sv @@
// Controller of the ranked insert table: the state machine that sequences
// scan, shift, place, drop and read, and the result valid flag. Depends on tkrit_pkg.
module tkrit_ctrl import tkrit_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  logic    i_s_tuser,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   w_out_free;

    assign w_out_free = !r_out_vld || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        n_out_vld = r_out_vld && !i_m_tready;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (t_op'(i_s_tuser) == OP_READ) ? ST_READ : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.pos_load = 1'b1;
                    if (i_sts.drop) begin
                        n_state = ST_DROP;
                    end else if (i_sts.no_move) begin
                        n_state = ST_PLACE;
                    end else begin
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: begin
                if (w_out_free) begin
                    o_cmd.place = 1'b1;
                    n_out_vld   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_DROP: begin
                if (w_out_free) begin
                    o_cmd.load_drop = 1'b1;
                    n_out_vld       = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_RDOUT;
            end
            ST_RDOUT: begin
                if (w_out_free) begin
                    o_cmd.load_rd = 1'b1;
                    n_out_vld     = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/top_k_ranked_insert_table_core.sv @@
// Top level of the ranked insert table: stream ports, controller and datapath.
// Depends on tkrit_pkg, tkrit_ctrl and tkrit_datapath.
//
//   Channel   Dir   Handshake                  Contents
//   s (in)    in    i_s_tvalid / o_s_tready    operation, score, steps, stamp, index
//   m (out)   out   o_m_tvalid / i_m_tready    rank, fill count, entry valid, entry
//
// An insert scans the stored entries one per cycle from the top (one read of
// the entry memory per cycle), then moves the entries below its place down one
// slot per cycle, then writes itself once the output register is free; an
// entry that would land past the last slot is dropped instead. A read fetches
// the indexed entry from the memory, then loads it into the result.
// Reset is synchronous and active low; of the table it clears only the fill
// count, since positions at or past the fill count read as empty.
// A held result stalls only the final step of the next item.
module top_k_ranked_insert_table_core import tkrit_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // Bits from 0: new_score[31:0], new_steps[55:32], new_stamp[87:56],
    // read_index[91:88], zero fill.
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // Bit 0: operation (0 insert, 1 read).
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // Bits from 0: rank[4:0], fill_count[9:5], entry_score[41:10],
    // entry_steps[65:42], entry_stamp[97:66], zero fill.
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // Bit 0: entry_valid.
    output logic                  o_m_tuser
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller only sequences; all table state lives in the datapath.
    tkrit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tkrit_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_s_tdata (i_s_tdata),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

`ifndef SYNTHESIS
    // An inserted entry can never rank below the table's own fill count.
    a_rank_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[RANK_W-1:0] != '0))
            |-> (o_m_tdata[RANK_W-1:0] <= o_m_tdata[2*RANK_W-1:RANK_W]))
        else $error("insert rank exceeds fill count");

    // A beat that carries a stored entry comes from a read and has no rank.
    a_read_has_no_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[RANK_W-1:0] == '0))
        else $error("read result carries a rank");

    // The memory port serves one purpose per cycle.
    a_one_mem_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.scan, w_cmd.shift, w_cmd.read, w_cmd.place}))
        else $error("memory port commanded twice in one cycle");
`endif

endmodule

@@ tb/sv/tb_rank_table_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the ranked insert table: keeps its own ranked table and
// compares every output beat with the predicted one. Depends on tkrit_pkg.
module tb_rank_table_checker import tkrit_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // Bits from 0: new_score, new_steps, new_stamp, read_index, zero fill.
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // Bit 0: operation.
    input  logic                  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // Bits from 0: rank, fill_count, entry_score, entry_steps, entry_stamp.
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    // Bit 0: entry_valid.
    input  logic                  i_m_tuser,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [RANK_W-1:0] fill;
        logic              valid;
        t_entry            entry;
    } t_outcome;

    // Predicted table contents; positions 0 .. slots_filled-1 are in use.
    t_entry   ranked_slots [DEPTH];
    int       slots_filled;
    t_outcome awaited_outcomes [$];

    // The new entry stands ahead when its score is higher, or on equal score
    // when its step count is lower; inverting the steps folds both into one
    // unsigned comparison.
    function automatic bit outranks(input t_entry cand, input t_entry held);
        return {cand.score, ~cand.steps} > {held.score, ~held.steps};
    endfunction

    function automatic t_outcome predict_item(input t_op op, input t_entry item,
                                              input logic [IDX_W-1:0] idx);
        t_outcome res;
        int       pos;
        res = '0;
        if (op == OP_INSERT) begin
            pos = slots_filled;
            for (int i = 0; i < slots_filled; i++) begin
                if (outranks(item, ranked_slots[i])) begin
                    pos = i;
                    break;
                end
            end
            if (pos < DEPTH) begin
                for (int i = DEPTH - 1; i > pos; i--) begin
                    ranked_slots[i] = ranked_slots[i-1];
                end
                ranked_slots[pos] = item;
                res.rank = RANK_W'(pos + 1);
                if (slots_filled < DEPTH) begin
                    slots_filled++;
                end
            end
            res.fill = RANK_W'(slots_filled);
        end else begin
            res.fill = RANK_W'(slots_filled);
            if (int'(idx) < slots_filled) begin
                res.valid = 1'b1;
                res.entry = ranked_slots[idx];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_outcome seen;
        t_outcome want;
        t_outcome predicted;
        if (!i_rst_n) begin
            slots_filled = 0;
            awaited_outcomes.delete();
        end else begin
            // Output side first, so a result never meets its own prediction.
            if (i_m_tvalid && i_m_tready) begin
                seen.rank  = i_m_tdata[RANK_W-1:0];
                seen.fill  = i_m_tdata[RANK_W +: RANK_W];
                seen.valid = i_m_tuser;
                seen.entry = i_m_tdata[2*RANK_W +: ENTRY_W];
                if (awaited_outcomes.size() == 0) begin
                    if (o_fail_count < REPORT_LIMIT) begin
                        $display("[%0t] unexpected result beat: rank %0d fill %0d valid %0b",
                                 $time, seen.rank, seen.fill, seen.valid);
                    end
                    o_fail_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (seen.rank !== want.rank || seen.fill !== want.fill ||
                        seen.valid !== want.valid ||
                        seen.entry.score !== want.entry.score ||
                        seen.entry.steps !== want.entry.steps ||
                        seen.entry.stamp !== want.entry.stamp) begin
                        if (o_fail_count < REPORT_LIMIT) begin
                            $display("[%0t] result mismatch (expected/actual): rank %0d/%0d",
                                     $time, want.rank, seen.rank);
                            $display("    fill %0d/%0d valid %0b/%0b score %h/%h",
                                     want.fill, seen.fill, want.valid, seen.valid,
                                     want.entry.score, seen.entry.score);
                            $display("    steps %h/%h stamp %h/%h",
                                     want.entry.steps, seen.entry.steps,
                                     want.entry.stamp, seen.entry.stamp);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predicted = predict_item(t_op'(i_s_tuser),
                                         t_entry'(i_s_tdata[ENTRY_W-1:0]),
                                         i_s_tdata[ENTRY_W +: IDX_W]);
                awaited_outcomes = {awaited_outcomes, predicted};
            end
        end
        o_pending = awaited_outcomes.size();
    end

endmodule

@@ tb/sv/tb_top_k_ranked_insert_table_core.sv @@
`timescale 1ns / 1ps
// Top of the ranked insert table testbench: clock, reset, input and output
// stimulus, verdict. Depends on tkrit_pkg, the block and tb_rank_table_checker.
module tb_top_k_ranked_insert_table_core;
    import tkrit_pkg::*;

    // The tail wait covers the longest insert.
    localparam int TAIL_CYCLES = 2 * DEPTH + 10;
    // Receiver hold-off used to fill the block and stall its input.
    localparam int LONG_HOLD   = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // Bits from 0: new_score, new_steps, new_stamp, read_index, zero fill.
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    // Bit 0: operation.
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // Bits from 0: rank, fill_count, entry_score, entry_steps, entry_stamp.
    logic [OUT_DATA_W-1:0] o_m_tdata;
    // Bit 0: entry_valid.
    logic                  o_m_tuser;

    int fail_count;
    int results_pending;

    // Idle rates in percent, set per phase by the stimulus process.
    int gap_pct   = 0;
    int stall_pct = 0;
    // Raised once to request the long receiver hold-off.
    bit hold_arm    = 1'b0;
    bit hold_served = 1'b0;
    int hold_left   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    top_k_ranked_insert_table_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    tb_rank_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    // Receiver: a fresh ready decision at every falling edge. When the
    // stimulus arms the hold-off, ready stays low until the LONG_HOLD count
    // kept here runs out, while the sender keeps offering beats.
    always @(negedge i_clk) begin
        if (hold_arm && !hold_served) begin
            hold_left   = LONG_HOLD;
            hold_served = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one beat. Called at a falling edge; returns at the falling edge
    // after the beat was taken, with valid still high, so the next call makes
    // exactly one change to valid in that time step.
    task automatic send_item(input t_op op, input t_entry item,
                             input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, idx, item};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic insert_entry(input logic [SCORE_W-1:0] score,
                                input logic [STEPS_W-1:0] steps,
                                input logic [STAMP_W-1:0] stamp);
        t_entry item;
        item.score = score;
        item.steps = steps;
        item.stamp = stamp;
        send_item(OP_INSERT, item, '0);
    endtask

    task automatic read_slot(input logic [IDX_W-1:0] idx);
        send_item(OP_READ, t_entry'(ENTRY_W'($urandom)), idx);
    endtask

    // Random beat. Scores come from three bands: full range, a few small
    // values that tie often and mostly fall off a full table, and a band
    // just under the maximum that keeps landing inside the table at
    // varying ranks. Step counts are often tiny so that full ties occur.
    task automatic send_random_item();
        t_entry item;
        t_op    op;
        op = ($urandom_range(99) < 50) ? OP_READ : OP_INSERT;
        case ($urandom_range(3))
            0:       item.score = $urandom;
            1:       item.score = SCORE_W'($urandom_range(6));
            default: item.score = '1 - SCORE_W'($urandom_range(12));
        endcase
        case ($urandom_range(2))
            0:       item.steps = STEPS_W'($urandom_range(3));
            1:       item.steps = '1 - STEPS_W'($urandom_range(3));
            default: item.steps = STEPS_W'($urandom);
        endcase
        item.stamp = $urandom;
        send_item(op, item, IDX_W'($urandom_range(15)));
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (results_pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int count, input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (count) begin
            send_random_item();
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: empty table, key extremes, ordering on each key,
        // full ties, a full table and a drop past the last slot.
        read_slot(4'd0);
        read_slot(4'd15);
        insert_entry('0, '0, '0);
        insert_entry('1, '1, '1);
        insert_entry('1, '1, 32'h5A5A_A5A5);   // full tie goes after
        insert_entry('1, 24'd7, 32'h1234_5678); // fewer steps goes first
        insert_entry(32'd100, 24'd9, 32'hCAFE_0001);
        insert_entry(32'd100, 24'd3, 32'hCAFE_0002);
        read_slot(4'd0);
        read_slot(4'd1);
        read_slot(4'd2);
        read_slot(4'd5);
        read_slot(4'd6);
        for (int i = 0; i < 10; i++) begin
            insert_entry(32'd50 + i, 24'(i), $urandom);
        end
        // The table is full; the lowest key ties with the last slot and drops.
        insert_entry('0, '0, 32'hDEAD_BEEF);
        insert_entry('0, '1, 32'hBEEF_DEAD);
        read_slot(4'd15);

        // Random part over the idling phases.
        run_phase(100, 0, 0);
        run_phase(90, 60, 0);
        wait_drained();
        run_phase(90, 0, 60);
        run_phase(90, 25, 25);

        // Long receiver hold-off while the sender keeps offering beats, so
        // the block fills and holds its input off.
        gap_pct   = 0;
        stall_pct = 0;
        hold_arm  = 1'b1;
        repeat (20) begin
            send_random_item();
        end
        wait_drained();
        run_phase(40, 0, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("top_k_ranked_insert_table_core verification clean");
        end else begin
            $display("top_k_ranked_insert_table_core verification failed");
        end
        $finish;
    end

    // Watchdog far past the slowest correct run.
    initial begin
        #5_000_000;
        $display("top_k_ranked_insert_table_core verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/tkrit_pkg.sv
src/tkrit_datapath.sv
src/tkrit_ctrl.sv
src/top_k_ranked_insert_table_core.sv
tb/sv/tb_rank_table_checker.sv
tb/sv/tb_top_k_ranked_insert_table_core.sv
